>>> sv/tcw_pkg.sv
// Shared types and constants for the text console character writer.
package tcw_pkg;

  localparam int unsigned ADDR_W = 11;
  localparam int unsigned CODE_W = 9;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CHAR_W = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_RDATA,
    ST_PUT,
    ST_COPY,
    ST_CLEAR,
    ST_BLANK,
    ST_FINISH
  } tcw_state_t;

endpackage

>>> sv/tcw_ifs.sv
// Handshake channels of the text console character writer.
interface tcw_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [tcw_pkg::CODE_W-1:0]  char_code;
  logic [tcw_pkg::ADDR_W-1:0]  read_address;
  modport source (output valid, opcode, char_code, read_address, input ready);
  modport sink   (input valid, opcode, char_code, read_address, output ready);
endinterface

interface tcw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CELL_W-1:0]  cell_value;
  logic [tcw_pkg::ADDR_W-1:0]  cursor_position;
  logic                        scrolled;
  modport source (output valid, cell_value, cursor_position, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_position, scrolled, output ready);
endinterface

interface tcw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::ATTR_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> sv/text_console_character_writer_unit.sv
// Top level: text-mode screen writer with cursor, scroll and cell read-back.
// A put that runs off the last row scrolls: the cell store, with one write and one read
// port, is walked by one address counter, copying one cell per cycle and then clearing
// the last row. After reset a clearing pass zeroes the store; no item is accepted until
// it ends, while attribute writes are taken at any time. One item is in work at a time;
// its result waits in an output register until taken, and the next item may be worked
// on meanwhile up to the point where its own result is due.
module text_console_character_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 24
) (
  input  logic          clk,
  input  logic          rst,
  tcw_req_if.sink       req,
  tcw_rsp_if.source     rsp,
  tcw_cfg_if.sink       cfg
);

  localparam int unsigned CELLS     = COLUMNS * ROWS;
  localparam int unsigned AW        = $clog2(CELLS);
  localparam int unsigned PW        = $clog2(CELLS + 1);
  localparam int unsigned CLW       = $clog2(COLUMNS);
  localparam int unsigned XW        = AW + tcw_pkg::ADDR_W;
  localparam int unsigned COPY_LEN  = CELLS - COLUMNS;

  localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_ROW  = AW'(COPY_LEN);
  localparam logic [CLW-1:0] LAST_COL  = CLW'(COLUMNS - 1);

  tcw_pkg::tcw_state_t state, state_next;

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] mem_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;

  logic [AW-1:0]              cnt;
  logic [AW-1:0]              cursor;
  logic [CLW-1:0]             col;
  logic [tcw_pkg::ATTR_W-1:0] attr;
  logic [tcw_pkg::CODE_W-1:0] code;
  logic [AW-1:0]              rd_addr;
  logic                       rd_oob;

  logic [tcw_pkg::CELL_W-1:0] work_cell;
  logic                       work_scrolled;
  logic                       res_valid;
  logic [tcw_pkg::CELL_W-1:0] res_cell;
  logic                       res_scrolled;
  logic [tcw_pkg::ADDR_W-1:0] res_cursor;
  logic [XW-1:0]              cur_x;
  logic [XW-1:0]              req_x;

  logic [PW-1:0]              pos_next;
  logic [CLW-1:0]             col_next;
  logic                       wrap;
  logic                       printable;
  logic                       slot_free;

  assign printable = (code != tcw_pkg::CODE_NEWLINE) && (code != tcw_pkg::CODE_BACKSPACE);
  assign slot_free = !res_valid || rsp.ready;
  assign req_x     = XW'(req.read_address);
  assign cur_x     = XW'(cursor);

  // Cursor step for a put
  always_comb begin
    priority if (code == tcw_pkg::CODE_NEWLINE) begin
      pos_next = PW'(cursor) + PW'(COLUMNS) - PW'(col);
      col_next = '0;
    end else if (code == tcw_pkg::CODE_BACKSPACE) begin
      pos_next = (cursor == '0) ? '0 : PW'(cursor) - PW'(1);
      col_next = (cursor == '0) ? '0 : ((col == '0) ? LAST_COL : col - CLW'(1));
    end else begin
      pos_next = PW'(cursor) + PW'(1);
      col_next = (col == LAST_COL) ? '0 : col + CLW'(1);
    end
    wrap = pos_next >= PW'(CELLS);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT:   if (cnt == LAST_CELL) state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.opcode == tcw_pkg::OP_READ) ? tcw_pkg::ST_READ : tcw_pkg::ST_PUT;
        end
      end
      tcw_pkg::ST_READ:   state_next = tcw_pkg::ST_RDATA;
      tcw_pkg::ST_RDATA:  state_next = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_PUT:    state_next = wrap ? tcw_pkg::ST_COPY : tcw_pkg::ST_BLANK;
      tcw_pkg::ST_COPY:   if (cnt == LAST_ROW) state_next = tcw_pkg::ST_CLEAR;
      tcw_pkg::ST_CLEAR:  if (cnt == LAST_CELL) state_next = tcw_pkg::ST_BLANK;
      tcw_pkg::ST_BLANK:  state_next = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_FINISH: if (slot_free) state_next = tcw_pkg::ST_IDLE;
      default:            state_next = tcw_pkg::ST_INIT;
    endcase
  end

  // Store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        mem_we = 1'b1;
      end
      tcw_pkg::ST_READ: begin
        mem_re = !rd_oob;
      end
      tcw_pkg::ST_PUT: begin
        mem_we    = printable;
        mem_waddr = cursor;
        mem_wdata = {attr, code[tcw_pkg::CHAR_W-1:0]};
      end
      tcw_pkg::ST_COPY: begin
        // read one row ahead, write the cell fetched last cycle
        mem_re    = (cnt != LAST_ROW);
        mem_raddr = cnt + AW'(COLUMNS);
        mem_we    = (cnt != '0);
        mem_waddr = cnt - AW'(1);
        mem_wdata = mem_q;
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cursor;
        mem_wdata = {attr, tcw_pkg::BLANK_CHAR};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tcw_pkg::ST_INIT;
      cnt          <= '0;
      cursor       <= '0;
      col          <= '0;
      attr         <= tcw_pkg::ATTR_RESET;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) attr <= cfg.data;
      if (state == tcw_pkg::ST_FINISH && slot_free) begin
        res_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        tcw_pkg::ST_INIT:  cnt <= (cnt == LAST_CELL) ? '0 : cnt + AW'(1);
        tcw_pkg::ST_PUT: begin
          cnt    <= '0;
          cursor <= wrap ? LAST_ROW : pos_next[AW-1:0];
          col    <= wrap ? '0 : col_next;
        end
        tcw_pkg::ST_COPY:  cnt <= (cnt == LAST_ROW) ? LAST_ROW : cnt + AW'(1);
        tcw_pkg::ST_CLEAR: cnt <= cnt + AW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  // Item capture, working result and output register
  always_ff @(posedge clk) begin
    if (state == tcw_pkg::ST_IDLE && req.valid) begin
      code          <= req.char_code;
      rd_addr       <= req_x[AW-1:0];
      rd_oob        <= req_x >= XW'(CELLS);
      work_cell     <= '0;
      work_scrolled <= 1'b0;
    end
    if (state == tcw_pkg::ST_RDATA) work_cell <= rd_oob ? '0 : mem_q;
    if (state == tcw_pkg::ST_PUT) work_scrolled <= wrap;
    // the output register only moves once the previous item has gone
    if (state == tcw_pkg::ST_FINISH && slot_free) begin
      res_cell     <= work_cell;
      res_scrolled <= work_scrolled;
      res_cursor   <= cur_x[tcw_pkg::ADDR_W-1:0];
    end
  end

  assign req.ready           = (state == tcw_pkg::ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = res_valid;
  assign rsp.cell_value      = res_cell;
  assign rsp.cursor_position = res_cursor;
  assign rsp.scrolled        = res_scrolled;

`ifndef SYNTHESIS
  a_cursor_in_store: assert property (@(posedge clk) disable iff (rst)
    cursor <= LAST_CELL)
    else $error("cursor beyond the cell store");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    col <= LAST_COL)
    else $error("column counter beyond the row");

  a_scroll_leaves_last_row: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::ST_BLANK && work_scrolled |-> cursor == LAST_ROW && col == '0)
    else $error("scroll left the cursor off the start of the last row");

  a_busy_while_walking: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_COPY || state == tcw_pkg::ST_CLEAR || state == tcw_pkg::ST_INIT)
      |-> !req.ready)
    else $error("item taken during a store walk");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !(res_valid && $rose(res_valid)))
    else $error("result raised in the cycle after an accept");
`endif

endmodule

>>> sim/text_console_character_writer_unit_test.sv
// Test of the text console character writer: screen predictor, item drivers and result checks.
package console_screen_check_pkg;
  import tcw_pkg::*;

  localparam int unsigned SCREEN_COLUMNS = 80;
  localparam int unsigned SCREEN_ROWS    = 24;
  localparam int unsigned SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic              opcode;
    logic [CODE_W-1:0] char_code;
    logic [ADDR_W-1:0] read_address;
  } console_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ADDR_W-1:0] cursor_position;
    logic              scrolled;
  } console_rsp_t;

  class screen_scoreboard;
    logic [CELL_W-1:0] cells [SCREEN_CELLS];
    int unsigned       cursor;
    logic [ATTR_W-1:0] attribute;
    console_rsp_t      awaited [$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor       = 0;
      attribute    = ATTR_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attribute = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Screen update for one accepted item; queues the result it should give.
    function void note_item(console_req_t item);
      console_rsp_t outcome;
      int unsigned  pos;
      int unsigned  i;
      outcome = '0;
      pos = cursor;
      if (pos >= SCREEN_CELLS) pos = 0;
      if (item.opcode == OP_READ) begin
        if (item.read_address < SCREEN_CELLS) outcome.cell_value = cells[item.read_address];
      end else begin
        if (item.char_code == CODE_NEWLINE) begin
          pos = pos + SCREEN_COLUMNS - pos % SCREEN_COLUMNS;
        end else if (item.char_code == CODE_BACKSPACE) begin
          if (pos > 0) pos = pos - 1;
        end else begin
          cells[pos] = {attribute, item.char_code[CHAR_W-1:0]};
          pos = pos + 1;
        end
        if (pos / SCREEN_COLUMNS >= SCREEN_ROWS) begin
          for (i = 0; i < SCREEN_CELLS - SCREEN_COLUMNS; i++) cells[i] = cells[i + SCREEN_COLUMNS];
          pos = pos - SCREEN_COLUMNS;
          for (i = pos; i < SCREEN_CELLS; i++) cells[i] = '0;
          outcome.scrolled = 1'b1;
        end
        cells[pos] = {attribute, BLANK_CHAR};
        cursor = pos;
      end
      outcome.cursor_position = ADDR_W'(cursor);
      awaited.push_back(outcome);
    endfunction

    function void check_result(console_rsp_t got);
      console_rsp_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result: cell %h cursor %0d scrolled %0b",
                   got.cell_value, got.cursor_position, got.scrolled);
        return;
      end
      want = awaited.pop_front();
      if (got.cell_value !== want.cell_value ||
          got.cursor_position !== want.cursor_position ||
          got.scrolled !== want.scrolled) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result %0d: expected cell %h cursor %0d scrolled %0b, %s %h %s %0d %s %0b",
                   results_seen, want.cell_value, want.cursor_position, want.scrolled,
                   "got cell", got.cell_value, "cursor", got.cursor_position,
                   "scrolled", got.scrolled);
      end
    endfunction
  endclass

endpackage

module text_console_character_writer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;
  import console_screen_check_pkg::*;

  // Slowest run: ~320 items, each a full scroll plus the longest sender gap and receiver
  // stall; taken four times over.
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned PHASE_ITEMS      = 50;
  localparam int unsigned LONG_HOLD_AT     = 70;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  logic             clk = 1'b0;
  logic             rst;
  tcw_req_if        req();
  tcw_rsp_if        rsp();
  tcw_cfg_if        cfg();
  screen_scoreboard board;
  int unsigned      cycle_count = 0;
  bit               sender_gapless = 1'b0;

  text_console_character_writer_unit #(
    .COLUMNS(SCREEN_COLUMNS),
    .ROWS   (SCREEN_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  function automatic console_req_t put_code(input logic [CODE_W-1:0] code);
    console_req_t item;
    item.opcode       = OP_PUT;
    item.char_code    = code;
    item.read_address = ADDR_W'($urandom);
    return item;
  endfunction

  function automatic console_req_t read_cell(input int unsigned addr);
    console_req_t item;
    item.opcode       = OP_READ;
    item.char_code    = CODE_W'($urandom);
    item.read_address = ADDR_W'(addr);
    return item;
  endfunction

  // newline_pct steers line length: low values let lines run off the right edge.
  function automatic console_req_t random_item(input int unsigned newline_pct);
    console_req_t item;
    int unsigned  pick;
    int unsigned  offset;
    item = put_code(CODE_W'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      if (pick < 3) begin
        item = read_cell($urandom_range(SCREEN_CELLS, (1 << ADDR_W) - 1));
      end else if (pick < 10) begin
        // close to the cursor, where fresh characters and blanks sit
        offset = $urandom_range(0, 6);
        item = read_cell((board.cursor + SCREEN_CELLS - 3 + offset) % SCREEN_CELLS);
      end else begin
        item = read_cell($urandom_range(0, SCREEN_CELLS - 1));
      end
    end else if (pick < 18 + newline_pct) begin
      item.char_code = CODE_NEWLINE;
    end else if (pick < 24 + newline_pct) begin
      item.char_code = CODE_BACKSPACE;
    end else if (pick < 29 + newline_pct) begin
      item.char_code = CODE_W'($urandom_range(257, 511));
    end
    return item;
  endfunction

  task automatic send_item(input console_req_t item);
    int unsigned gap;
    gap = sender_gapless ? 0 : idle_gap();
    req.valid        <= 1'b1;
    req.opcode       <= item.opcode;
    req.char_code    <= item.char_code;
    req.read_address <= item.read_address;
    do @(posedge clk); while (!req.ready);
    board.note_item(item);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    board.set_attribute(value);
    cfg.valid <= 1'b0;
  endtask

  initial begin : result_sink
    console_rsp_t got;
    int unsigned  stall_left;
    int unsigned  mode_left;
    bit           steady;
    bit           long_hold_done;
    stall_left     = 0;
    mode_left      = 0;
    steady         = 1'b0;
    long_hold_done = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        got.cell_value      = rsp.cell_value;
        got.cursor_position = rsp.cursor_position;
        got.scrolled        = rsp.scrolled;
        board.check_result(got);
      end
      if (!long_hold_done && board.results_seen >= LONG_HOLD_AT) begin
        // hold off long enough for the block to fill and stall its input
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_left != 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!steady) stall_left = idle_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned newline_pct [PHASES];
    int unsigned phase;
    int unsigned n;
    logic [ATTR_W-1:0] attr;
    board = new();
    newline_pct = '{30, 25, 1, 1, 15, 15};
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.opcode       <= OP_PUT;
    req.char_code    <= '0;
    req.read_address <= '0;
    cfg.valid        <= 1'b0;
    cfg.data         <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset attribute.
    send_item(put_code(CODE_BACKSPACE));   // at cell zero: cursor stays, blank still written
    send_item(read_cell(0));
    send_item(put_code(9'h041));
    send_item(put_code(9'h000));
    send_item(put_code(9'h0FF));
    send_item(put_code(9'h1FF));           // top bit dropped on write
    send_item(put_code(9'h10A));           // low byte looks like newline, still printed
    send_item(put_code(9'h0E4));           // left-arrow code is plain text here
    send_item(put_code(CODE_NEWLINE));
    send_item(put_code(CODE_BACKSPACE));   // back over the row start
    send_item(read_cell(0));
    send_item(read_cell(5));
    send_item(read_cell(79));
    send_item(read_cell((1 << ADDR_W) - 1));
    send_item(read_cell(SCREEN_CELLS));
    send_item(read_cell(SCREEN_CELLS - 1));
    wait_drained();
    write_attribute(8'hFF);
    send_item(put_code(9'h07E));
    send_item(read_cell(79));
    wait_drained();
    write_attribute(8'h00);
    send_item(put_code(9'h031));
    send_item(read_cell(80));

    // Random phases, each under its own attribute.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        1: attr = 8'hFF;
        2: attr = 8'h00;
        default: attr = ATTR_W'($urandom);
      endcase
      write_attribute(attr);
      sender_gapless = (phase == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_drained();
        send_item(random_item(newline_pct[phase]));
      end
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
